@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GTP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("go_to_point_steering check failed");

// Next-cycle implication.
`define GTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("go_to_point_steering check failed");

`endif

@@ src/gtp_pkg.sv @@
// Package of the go-to-point steering block: widths, tables, command types.
// No dependencies.
package gtp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = (CORDIC_STEPS > 16) ? 5 : 4;
  localparam int CW = 28;            // CORDIC x/y width
  localparam int ZW = 25;            // CORDIC angle width, Q20
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ADVANCE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DISTANCE  = CFG_IDX_W'(3);

  localparam logic signed [ZW-1:0] PI_Q20 = ZW'(3294199);
  localparam logic signed [17:0] PI_Q12 = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic [23:0] INV_K_Q24 = 24'd10188014;
  localparam logic [19:0] LOG2_10X4_Q16 = 20'd870824;

  localparam logic [19:0] ATAN_Q20 [24] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
    20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512, 20'd256,
    20'd128, 20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2, 20'd1, 20'd0,
    20'd0, 20'd0
  };

  localparam logic [29:0] POW2_FRAC_Q30 [12] = '{
    30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
    30'd1072289172, 30'd1073015252, 30'd1073378477, 30'd1073560135
  };

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ARRIVE,
    RES_ROTATE,
    RES_ADVANCE
  } res_kind_e;

  typedef struct packed {
    logic       accept;
    logic       cordic_step;
    logic       post;
    logic       decide;
    logic       tmul;
    logic       tload;
    logic       frac_step;
    logic       num;
    logic       rnd;
    logic       div_step;
    logic       load_out;
    res_kind_e  kind;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic arrive;
    logic rotate;
    logic ramp;
  } sts_t;

endpackage

@@ src/gtp_if.sv @@
// Channel interfaces of the go-to-point steering block: input item,
// result item and configuration write. Depends on gtp_pkg.
interface gtp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] x_mm;
  logic signed [15:0] z_mm;
  logic signed [14:0] heading;
  modport source (output valid, opcode, x_mm, z_mm, heading, input ready);
  modport sink (input valid, opcode, x_mm, z_mm, heading, output ready);
endinterface

interface gtp_out_if;
  logic               valid;
  logic               ready;
  logic               command_valid;
  logic        [11:0] advance_speed;
  logic signed [14:0] turn_rate;
  logic               arrived;
  modport source (output valid, command_valid, advance_speed, turn_rate, arrived,
                  input ready);
  modport sink (input valid, command_valid, advance_speed, turn_rate, arrived,
                output ready);
endinterface

interface gtp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gtp_pkg::CFG_IDX_W-1:0]  index;
  logic [gtp_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/gtp_datapath.sv @@
// Datapath: goal and config registers, shared CORDIC, turn factor and divider.
// Driven by gtp_ctrl through gtp_pkg::cmd_t; depends on gtp_pkg.
module gtp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gtp_pkg::cmd_t                  cmd_i,
  output gtp_pkg::sts_t                  sts_o,
  input  logic                           in_opcode_i,
  input  logic signed [15:0]             in_x_mm_i,
  input  logic signed [15:0]             in_z_mm_i,
  input  logic signed [14:0]             in_heading_i,
  input  logic                           cfg_we_i,
  input  logic [gtp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gtp_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic                           command_valid_o,
  output logic [11:0]                    advance_speed_o,
  output logic signed [14:0]             turn_rate_o,
  output logic                           arrived_o
);
  import gtp_pkg::*;

  logic [11:0] stop_q, max_adv_q, slow_q;
  logic [13:0] thr_q;
  logic signed [15:0] goal_x_q, goal_z_q;
  logic signed [14:0] hd_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic signed [17:0] beta_q;
  logic [50:0] prod_q;
  logic [11:0] dist_q;
  logic [27:0] sq_q;
  logic [47:0] tprod_q;
  logic [20:0] t_q;
  logic [30:0] acc_q;
  logic [42:0] num_q;
  logic [55:0] rem_q;
  logic [11:0] quo_q;

  logic signed [16:0] dx, dz;
  logic signed [CW-1:0] x0, y0, xsh, ysh;
  logic signed [ZW-1:0] atan_v;
  logic signed [ZW:0] ang_r;
  logic signed [17:0] braw, b1, b2, b3, b4;
  logic [26:0] mag;
  logic [51:0] dist_sum;
  logic [19:0] dist_full;
  logic [16:0] mb;
  logic [60:0] acc_prod;
  logic [8:0] n_int;
  logic [30:0] factor;
  logic [43:0] rnd_sum;
  logic [55:0] dsh;

  always_comb begin
    dx = 17'(goal_x_q) - 17'(in_x_mm_i);
    dz = 17'(goal_z_q) - 17'(in_z_mm_i);
    x0 = CW'(dz) <<< 8;
    y0 = CW'(dx) <<< 8;
    xsh = x_q >>> cmd_i.cnt;
    ysh = y_q >>> cmd_i.cnt;
    atan_v = ZW'(signed'({1'b0, ATAN_Q20[5'(cmd_i.cnt)]}));
    ang_r = (ZW + 1)'(z_q) + (ZW + 1)'(128);
    braw = 18'(ang_r >>> 8) + 18'(hd_q);
    b1 = (braw > PI_Q12) ? braw - TWO_PI_Q12 : braw;
    b2 = (b1 > PI_Q12) ? b1 - TWO_PI_Q12 : b1;
    b3 = (b2 < -PI_Q12) ? b2 + TWO_PI_Q12 : b2;
    b4 = (b3 < -PI_Q12) ? b3 + TWO_PI_Q12 : b3;
    mag = x_q[CW-1] ? 27'd0 : x_q[26:0];
    dist_sum = 52'(prod_q) + (52'd1 << 31);
    dist_full = dist_sum[51:32];
    mb = beta_q[17] ? 17'(-beta_q) : 17'(beta_q);
    acc_prod = 61'(acc_q) * 61'(POW2_FRAC_Q30[4'(11 - 32'(cmd_i.cnt))]) + (61'd1 << 29);
    n_int = t_q[20:12];
    factor = (n_int >= 9'd31) ? 31'd0 : (acc_q >> n_int[4:0]);
    rnd_sum = 44'(num_q) + (44'd1 << 29);
    dsh = 56'(slow_q) << (30 + 32'(cmd_i.cnt));
    sts_o.arrive = dist_full < 20'(stop_q);
    sts_o.rotate = mb > 17'(thr_q);
    sts_o.ramp = (slow_q != 12'd0) && (dist_full < 20'(slow_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 12'd120;
      max_adv_q <= 12'd1000;
      thr_q <= 14'd410;
      slow_q <= 12'd1000;
      goal_x_q <= '0;
      goal_z_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STOP_DISTANCE:  stop_q <= cfg_data_i[11:0];
          REG_MAX_ADVANCE:    max_adv_q <= cfg_data_i[11:0];
          REG_TURN_THRESHOLD: thr_q <= cfg_data_i[13:0];
          REG_SLOW_DISTANCE:  slow_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && !in_opcode_i) begin
        goal_x_q <= in_x_mm_i;
        goal_z_q <= in_z_mm_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hd_q <= in_heading_i;
      if (x0 < 0) begin
        z_q <= (y0 >= 0) ? PI_Q20 : -PI_Q20;
        x_q <= -x0;
        y_q <= -y0;
      end else begin
        z_q <= '0;
        x_q <= x0;
        y_q <= y0;
      end
    end
    if (cmd_i.cordic_step) begin
      if (y_q >= 0) begin
        x_q <= x_q + ysh;
        y_q <= y_q - xsh;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ysh;
        y_q <= y_q + xsh;
        z_q <= z_q - atan_v;
      end
    end
    if (cmd_i.post) begin
      beta_q <= b4;
      prod_q <= 51'(mag) * 51'(INV_K_Q24);
    end
    if (cmd_i.decide) begin
      dist_q <= dist_full[11:0];
      sq_q <= 28'(mb[13:0]) * 28'(mb[13:0]);
    end
    if (cmd_i.tmul) tprod_q <= 48'(sq_q) * 48'(LOG2_10X4_Q16);
    if (cmd_i.tload) begin
      t_q <= 21'((49'(tprod_q) + (49'd1 << 27)) >> 28);
      acc_q <= 31'd1 << 30;
    end
    if (cmd_i.frac_step && t_q[cmd_i.cnt[3:0]]) acc_q <= acc_prod[60:30];
    if (cmd_i.num) num_q <= 43'(max_adv_q) * 43'(factor);
    if (cmd_i.rnd) begin
      if (sts_o.ramp) begin
        rem_q <= 56'(num_q) * 56'(dist_q) + (56'(slow_q) << 29);
        quo_q <= '0;
      end else begin
        quo_q <= rnd_sum[41:30];
      end
    end
    if (cmd_i.div_step && rem_q >= dsh) begin
      rem_q <= rem_q - dsh;
      quo_q[cmd_i.cnt[3:0]] <= 1'b1;
    end
    if (cmd_i.load_out) begin
      command_valid_o <= cmd_i.kind != RES_ZERO;
      arrived_o <= cmd_i.kind == RES_ARRIVE;
      advance_speed_o <= (cmd_i.kind == RES_ADVANCE) ? quo_q : 12'd0;
      turn_rate_o <= (cmd_i.kind == RES_ROTATE) ? beta_q[14:0] : 15'sd0;
    end
  end

endmodule

@@ src/gtp_ctrl.sv @@
// Controller: sequences one item through the datapath and owns armed state
// and the result valid flag. Depends on gtp_pkg.
module gtp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_opcode_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  gtp_pkg::sts_t  sts_i,
  output gtp_pkg::cmd_t  cmd_o
);
  import gtp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CORD  = 4'd1;
  localparam logic [3:0] S_POST  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_TMUL  = 4'd4;
  localparam logic [3:0] S_TLOAD = 4'd5;
  localparam logic [3:0] S_FRAC  = 4'd6;
  localparam logic [3:0] S_NUM   = 4'd7;
  localparam logic [3:0] S_RND   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  res_kind_e kind_q, kind_d;
  logic armed_q, armed_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    kind_d = kind_q;
    armed_d = armed_q;
    cmd_o = '0;
    cmd_o.cnt = cnt_q;
    cmd_o.kind = kind_q;
    in_ready_o = state_q == S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          kind_d = RES_ZERO;
          cnt_d = '0;
          if (!in_opcode_i) begin
            armed_d = 1'b1;
            state_d = S_DONE;
          end else if (!armed_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_CORD;
          end
        end
      end
      S_CORD: begin
        cmd_o.cordic_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = S_POST;
      end
      S_POST: begin
        cmd_o.post = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        if (sts_i.arrive) begin
          armed_d = 1'b0;
          kind_d = RES_ARRIVE;
          state_d = S_DONE;
        end else if (sts_i.rotate) begin
          kind_d = RES_ROTATE;
          state_d = S_DONE;
        end else begin
          kind_d = RES_ADVANCE;
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d = S_TLOAD;
      end
      S_TLOAD: begin
        cmd_o.tload = 1'b1;
        cnt_d = '0;
        state_d = S_FRAC;
      end
      S_FRAC: begin
        cmd_o.frac_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(11)) state_d = S_NUM;
      end
      S_NUM: begin
        cmd_o.num = 1'b1;
        state_d = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        cnt_d = CNT_W'(11);
        state_d = sts_i.ramp ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      kind_q <= RES_ZERO;
      armed_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      kind_q <= kind_d;
      armed_q <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/go_to_point_steering.sv @@
// Top level of the go-to-point steering block: controller plus datapath.
// Depends on gtp_pkg, gtp_if, gtp_ctrl and gtp_datapath.
//
// Use: a goal item (opcode 0) stores the target and arms the controller;
// a tick item (opcode 1) carries the pose and yields one speed command.
// Every input item produces exactly one result item, all zero for a goal
// or for a tick while disarmed. Arrival disarms until the next goal.
// Config writes are taken every cycle and only while idle should they
// change; they apply to the next item.
// A goal or disarmed tick goes straight to the output register; an arrival
// or rotation tick runs the CORDIC, post step and decision; an advance
// tick then adds the turn factor and rounding, plus the division when
// inside the slow distance. The iterative CORDIC, the bit-serial turn
// factor and the restoring divider share one sequencer, so one item is in
// flight at a time. The next item is taken as soon as its result sits in
// the output register; a stalled receiver holds that register and blocks
// the following result only. Reset disarms and loads the default config.
module go_to_point_steering (
  input  logic       clk_i,
  input  logic       rst_ni,
  gtp_in_if.sink     in_ch_i,
  gtp_out_if.source  out_ch_o,
  gtp_cfg_if.sink    cfg_ch_i
);
  import gtp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch_i.ready = 1'b1;

  gtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_opcode_i (in_ch_i.opcode),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gtp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_opcode_i     (in_ch_i.opcode),
    .in_x_mm_i       (in_ch_i.x_mm),
    .in_z_mm_i       (in_ch_i.z_mm),
    .in_heading_i    (in_ch_i.heading),
    .cfg_we_i        (cfg_ch_i.valid),
    .cfg_index_i     (cfg_ch_i.index),
    .cfg_data_i      (cfg_ch_i.data),
    .command_valid_o (out_ch_o.command_valid),
    .advance_speed_o (out_ch_o.advance_speed),
    .turn_rate_o     (out_ch_o.turn_rate),
    .arrived_o       (out_ch_o.arrived)
  );

endmodule

@@ src/gtp_checker.sv @@
// Port-level checks of go_to_point_steering on the result channel,
// bound to the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module gtp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               command_valid_i,
  input logic        [11:0] advance_speed_i,
  input logic signed [14:0] turn_rate_i,
  input logic               arrived_i
);
  `GTP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(advance_speed_i) && $stable(turn_rate_i))
  `GTP_ASSERT_IMPL(a_idle_zero, out_valid_i && !command_valid_i,
    advance_speed_i == 12'd0 && turn_rate_i == 15'sd0 && !arrived_i)
  `GTP_ASSERT_IMPL(a_arrive_stop, out_valid_i && arrived_i,
    command_valid_i && advance_speed_i == 12'd0 && turn_rate_i == 15'sd0)
  `GTP_ASSERT_IMPL(a_turn_xor_adv, out_valid_i && turn_rate_i != 15'sd0,
    advance_speed_i == 12'd0)
endmodule

bind go_to_point_steering gtp_checker u_gtp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_ch_o.valid),
  .out_ready_i     (out_ch_o.ready),
  .command_valid_i (out_ch_o.command_valid),
  .advance_speed_i (out_ch_o.advance_speed),
  .turn_rate_i     (out_ch_o.turn_rate),
  .arrived_i       (out_ch_o.arrived)
);
